// ===== rtl/dpmd_pkg.sv =====
// shared types and constants of the dual pi motor drive
`default_nettype none
package dpmd_pkg;

	localparam int SPEED_W   = 16;
	localparam int ERR_W     = SPEED_W + 1;
	localparam int SUM_W     = 32;
	localparam int KP_W      = 16;
	localparam int KI_W      = 24;
	localparam int PERIOD_W  = 16;
	localparam int CFG_W     = 24;
	localparam int PTERM_W   = KP_W + ERR_W;
	localparam int ITERM_W   = KI_W + SUM_W;
	localparam int DRIVE_W   = ITERM_W + 2;
	localparam int FRAC_W    = 16;
	localparam int DUTY_W    = 16;
	localparam int P_SHIFT   = 8;

	localparam logic [KP_W-1:0]     KP_RESET     = 16'd256;
	localparam logic [KI_W-1:0]     KI_RESET     = 24'd0;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd7200;
	localparam logic [PERIOD_W-1:0] LIMIT_MARGIN = 16'd100;
	localparam logic [DRIVE_W-1:0]  DRIVE_OFFSET_Q = DRIVE_W'(1000) << FRAC_W;

	typedef enum logic [2:0] {
		REG_P_GAIN_A   = 3'd0,
		REG_I_GAIN_A   = 3'd1,
		REG_P_GAIN_B   = 3'd2,
		REG_I_GAIN_B   = 3'd3,
		REG_PWM_PERIOD = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic              forward;
		logic [DUTY_W-1:0] duty;
	} drive_out_t;

endpackage
`default_nettype wire

// ===== rtl/dpmd_clamp.sv =====
// drive sum, limit clamp and split into direction and magnitude
`default_nettype none
module dpmd_clamp (
	input  wire logic signed [dpmd_pkg::PTERM_W-1:0]  p_term,
	input  wire logic signed [dpmd_pkg::ITERM_W-1:0]  i_term,
	input  wire logic        [dpmd_pkg::PERIOD_W-1:0] pwm_period,
	output dpmd_pkg::drive_out_t                      result
);

	localparam int DW = dpmd_pkg::DRIVE_W;

	logic        [dpmd_pkg::PERIOD_W-1:0] limit;
	logic signed [DW-1:0]                 drive;
	logic signed [DW-1:0]                 lim_q;
	logic signed [DW-1:0]                 neg_lim_q;
	logic signed [DW-1:0]                 neg_drive;

	always_comb begin
		if (pwm_period > dpmd_pkg::LIMIT_MARGIN) begin
			limit = pwm_period - dpmd_pkg::LIMIT_MARGIN;
		end else begin
			limit = '0;
		end
		lim_q     = $signed(DW'(limit) << dpmd_pkg::FRAC_W);
		neg_lim_q = -lim_q;
		drive     = (DW'(p_term) <<< dpmd_pkg::P_SHIFT) + DW'(i_term)
			+ $signed(dpmd_pkg::DRIVE_OFFSET_Q);
		neg_drive = -drive;

		if (drive > lim_q) begin
			result.forward = (limit != '0);
			result.duty    = limit;
		end else if (drive < neg_lim_q) begin
			result.forward = 1'b0;
			result.duty    = limit;
		end else if (drive > 0) begin
			result.forward = 1'b1;
			result.duty    = drive[dpmd_pkg::FRAC_W +: dpmd_pkg::DUTY_W];
		end else begin
			result.forward = 1'b0;
			result.duty    = neg_drive[dpmd_pkg::FRAC_W +: dpmd_pkg::DUTY_W];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dual_pi_motor_drive_unit.sv =====
// top level: two-channel positional pi speed controller
// pipeline: 4 stages, input register, stage 2, stage 3 and output register
// throughput: one item per cycle while the output is not stalled, set by the
// per-channel error sum register that stage 1 reads and writes in the same cycle
// reset: error sums cleared, gains and period at defaults, pipeline empty
// stages fill over bubbles, so items are taken while a result waits at the output
`default_nettype none
module dual_pi_motor_drive_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // target_speed[15:0], measured_speed[31:16]
	input  wire logic [0:0]  s_tuser,   // channel
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // forward[0], duty[16:1], zero[23:17]
	output logic [0:0]       m_tuser,   // out_channel
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [dpmd_pkg::CFG_W-1:0] cfg_data
);

	localparam int SW = dpmd_pkg::SPEED_W;
	localparam int EW = dpmd_pkg::ERR_W;
	localparam int MW = dpmd_pkg::SUM_W;

	// configuration registers
	logic [dpmd_pkg::KP_W-1:0]     p_gain_a_q, p_gain_b_q;
	logic [dpmd_pkg::KI_W-1:0]     i_gain_a_q, i_gain_b_q;
	logic [dpmd_pkg::PERIOD_W-1:0] pwm_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_a_q   <= dpmd_pkg::KP_RESET;
			i_gain_a_q   <= dpmd_pkg::KI_RESET;
			p_gain_b_q   <= dpmd_pkg::KP_RESET;
			i_gain_b_q   <= dpmd_pkg::KI_RESET;
			pwm_period_q <= dpmd_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			case (dpmd_pkg::cfg_reg_t'(cfg_index))
				dpmd_pkg::REG_P_GAIN_A:   p_gain_a_q   <= cfg_data[dpmd_pkg::KP_W-1:0];
				dpmd_pkg::REG_I_GAIN_A:   i_gain_a_q   <= cfg_data[dpmd_pkg::KI_W-1:0];
				dpmd_pkg::REG_P_GAIN_B:   p_gain_b_q   <= cfg_data[dpmd_pkg::KP_W-1:0];
				dpmd_pkg::REG_I_GAIN_B:   i_gain_b_q   <= cfg_data[dpmd_pkg::KI_W-1:0];
				dpmd_pkg::REG_PWM_PERIOD: pwm_period_q <= cfg_data[dpmd_pkg::PERIOD_W-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// stage valids and per-stage load enables; a stage loads when it is
	// empty or its contents move on, so bubbles collapse
	logic v_s1, v_s2, v_s3, out_v_q;
	logic en_s1, en_s2, en_s3, en_out;

	assign en_out   = !out_v_q || m_tready;
	assign en_s3    = !v_s3 || en_out;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en_s1)  v_s1    <= s_tvalid;
			if (en_s2)  v_s2    <= v_s1;
			if (en_s3)  v_s3    <= v_s2;
			if (en_out) out_v_q <= v_s3;
		end
	end

	// stage 1: input register
	logic                 ch_s1;
	logic signed [SW-1:0] target_s1, measured_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ch_s1       <= s_tuser[0];
			target_s1   <= s_tdata[SW-1:0];
			measured_s1 <= s_tdata[2*SW-1:SW];
		end
	end

	// error and saturating error sum; the sum register is written as the
	// item leaves stage 1, so a following item of the same channel sees it
	logic signed [MW-1:0] error_sum_q [2];
	logic signed [EW-1:0] err_c;
	logic signed [MW:0]   sum_wide_c;
	logic signed [MW-1:0] sum_c;

	always_comb begin
		err_c      = EW'(target_s1) - EW'(measured_s1);
		sum_wide_c = (MW+1)'(error_sum_q[ch_s1]) + (MW+1)'(err_c);
		if (sum_wide_c[MW] != sum_wide_c[MW-1]) begin
			// overflow: pin to the bound on the side of the true sign
			sum_c = {sum_wide_c[MW], {(MW-1){!sum_wide_c[MW]}}};
		end else begin
			sum_c = sum_wide_c[MW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q[0] <= '0;
			error_sum_q[1] <= '0;
		end else if (v_s1 && en_s2) begin
			error_sum_q[ch_s1] <= sum_c;
		end
	end

	// stage 2: error and new sum registered
	logic                 ch_s2;
	logic signed [EW-1:0] err_s2;
	logic signed [MW-1:0] sum_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ch_s2  <= ch_s1;
			err_s2 <= err_c;
			sum_s2 <= sum_c;
		end
	end

	// gain selection and the two products
	logic signed [dpmd_pkg::KP_W:0]      kp_c;
	logic signed [dpmd_pkg::KI_W:0]      ki_c;
	logic signed [dpmd_pkg::PTERM_W-1:0] p_term_c;
	logic signed [dpmd_pkg::ITERM_W-1:0] i_term_c;

	always_comb begin
		kp_c     = $signed({1'b0, ch_s2 ? p_gain_b_q : p_gain_a_q});
		ki_c     = $signed({1'b0, ch_s2 ? i_gain_b_q : i_gain_a_q});
		p_term_c = dpmd_pkg::PTERM_W'(kp_c) * dpmd_pkg::PTERM_W'(err_s2);
		i_term_c = dpmd_pkg::ITERM_W'(ki_c) * dpmd_pkg::ITERM_W'(sum_s2);
	end

	// stage 3: products registered
	logic                                ch_s3;
	logic signed [dpmd_pkg::PTERM_W-1:0] p_term_s3;
	logic signed [dpmd_pkg::ITERM_W-1:0] i_term_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ch_s3     <= ch_s2;
			p_term_s3 <= p_term_c;
			i_term_s3 <= i_term_c;
		end
	end

	// drive sum, clamp and split
	dpmd_pkg::drive_out_t drive_c;

	dpmd_clamp u_clamp (
		.p_term     (p_term_s3),
		.i_term     (i_term_s3),
		.pwm_period (pwm_period_q),
		.result     (drive_c)
	);

	// output register
	logic                 out_ch_q;
	dpmd_pkg::drive_out_t out_q;

	always_ff @(posedge clk) begin
		if (en_out) begin
			out_ch_q <= ch_s3;
			out_q    <= drive_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_ch_q;
	assign m_tdata  = {7'd0, out_q.duty, out_q.forward};

endmodule
`default_nettype wire

// ===== rtl/dpmd_checker.sv =====
// port-level checks of the dual pi motor drive, bound to the top level
`default_nettype none
module dpmd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// items accepted but not yet delivered; the pipe holds at most four
	logic [2:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
		end
	end

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// no result without an item in flight
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 3'd0)
		else $error("result with nothing in flight");

	// never more items in flight than pipeline stages
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("too many items in flight");

	// an empty pipe always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> s_tready)
		else $error("empty pipe not ready");

endmodule

bind dual_pi_motor_drive_unit dpmd_checker u_dpmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
